// File: src/nlqt_pkg.sv
// Shared types, constants and the decay table for the neighbor link quality tracker.
// Used by every module in src; depends on nothing.
package nlqt_pkg;

  localparam int unsigned EntriesDefault = 16;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned SumW    = 48;
  localparam int unsigned WsumW   = 32;
  localparam int unsigned TauW    = 20;
  localparam int unsigned DenW    = 30;
  localparam int unsigned DivNumW = 52;
  localparam int unsigned DivQW   = 21;
  localparam int unsigned ExpW    = 5;

  localparam logic [DenW-1:0]  DenReset = 30'd1000000;
  localparam logic [9:0]       UsPerMs  = 10'd1000;
  localparam logic [16:0]      WOne     = 17'h10000;
  localparam logic [WsumW-1:0] WsumOne  = 32'h0001_0000;
  localparam logic [ExpW-1:0]  ExpLast  = 5'd20;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_SPARE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_INSERTED       = 4'd0,
    ST_UPDATED        = 4'd1,
    ST_BAD_IGNORED    = 4'd2,
    ST_REPEAT_IGNORED = 4'd3,
    ST_TABLE_FULL     = 4'd4,
    ST_FOUND          = 4'd5,
    ST_NOT_FOUND      = 4'd6,
    ST_REMOVED        = 4'd7,
    ST_REMOVE_MISSING = 4'd8
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        neighbor_addr;
    logic signed [15:0] signal;
    logic signed [15:0] quality;
    logic [47:0]        sample_time_us;
    logic [47:0]        now_us;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [15:0] avg_signal;
    logic signed [15:0] avg_quality;
    logic [47:0]        last_update_us;
  } out_beat_t;

  typedef struct packed {
    logic [31:0]           addr;
    logic [TimeW-1:0]      last_sample;
    logic [TimeW-1:0]      upd_time;
    logic signed [SumW-1:0] sig_sum;
    logic [WsumW-1:0]      sig_wsum;
    logic signed [SumW-1:0] qual_sum;
    logic [WsumW-1:0]      qual_wsum;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_CLR_VALID,
    OP_NEW,
    OP_W_ONE,
    OP_W_ZERO,
    OP_DIV_R,
    OP_EXP,
    OP_W_P,
    OP_MAG,
    OP_MLO,
    OP_MHI,
    OP_MWS,
    OP_COMB,
    OP_ADD,
    OP_NORM,
    OP_WRITE,
    OP_QDIV,
    OP_QRES
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            ch;
    logic [ExpW-1:0] k;
    logic            rd_en;
    logic            cmp_en;
    logic            status_we;
    status_e         status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       bad;
    logic       hit;
    logic       free;
    logic       rpt;
    logic       older;
    logic       w_zero;
    logic       div_done;
  } sts_t;

  // exp(-2^(k-16)) in Q0.32, one factor per bit of the Q16 ratio
  function automatic logic [31:0] decay_c(input logic [ExpW-1:0] k);
    logic [31:0] c;
    case (k)
      5'd0:    c = 32'd4294901760;
      5'd1:    c = 32'd4294836226;
      5'd2:    c = 32'd4294705160;
      5'd3:    c = 32'd4294443040;
      5'd4:    c = 32'd4293918848;
      5'd5:    c = 32'd4292870656;
      5'd6:    c = 32'd4290775039;
      5'd7:    c = 32'd4286586875;
      5'd8:    c = 32'd4278222805;
      5'd9:    c = 32'd4261543595;
      5'd10:   c = 32'd4228380000;
      5'd11:   c = 32'd4162825044;
      5'd12:   c = 32'd4034748382;
      5'd13:   c = 32'd3790295335;
      5'd14:   c = 32'd3344923893;
      5'd15:   c = 32'd2605029347;
      5'd16:   c = 32'd1580030169;
      5'd17:   c = 32'd581260615;
      5'd18:   c = 32'd78665070;
      5'd19:   c = 32'd1440801;
      5'd20:   c = 32'd483;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

// File: src/nlqt_div.sv
// Restoring divider, one quotient bit per cycle, 21 quotient bits.
// Depends on nlqt_pkg.
module nlqt_div
  import nlqt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [31:0]        den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DivQW-1:0]   quo_o,
  output logic               ovf_o
);

  logic             busy_q, done_q;
  logic [ExpW-1:0]  cnt_q;
  logic [31:0]      rem_q, den_q;
  logic [DivQW-1:0] low_q, quo_q;
  logic             ovf_q;
  logic [32:0]      trial, diff;
  logic             ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, low_q[DivQW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  // sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= ExpW'(DivQW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ExpW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift the remainder and collect quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[DivNumW-1:DivQW]};
      low_q <= num_i[DivQW-1:0];
      den_q <= den_i;
      ovf_q <= {1'b0, num_i[DivNumW-1:DivQW]} >= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      low_q <= {low_q[DivQW-2:0], 1'b0};
      quo_q <= {quo_q[DivQW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

// File: src/nlqt_dp.sv
// Datapath: neighbor table memory, valid bits, decay weight and averaging arithmetic.
// Depends on nlqt_pkg and nlqt_div.
module nlqt_dp
  import nlqt_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  in_beat_t        in_i,
  input  logic            cfg_we_i,
  input  logic [TauW-1:0] cfg_data_i,
  input  cmd_t            cmd_i,
  input  logic [IW-1:0]   rd_idx_i,
  input  logic [IW-1:0]   cmp_idx_i,
  output sts_t            sts_o,
  output out_beat_t       out_o
);

  entry_t mem_q [ENTRIES];
  entry_t rd_q;
  entry_t wr_data;
  logic   wr_en;
  logic [IW-1:0] wr_idx;

  logic [ENTRIES-1:0] valid_q;
  logic [DenW-1:0]    den_q;
  in_beat_t           in_q;
  logic               hit_q, free_q;
  logic [IW-1:0]      hit_idx_q, free_idx_q;
  logic [TimeW-1:0]   last_smp_q, last_upd_q;
  logic signed [SumW-1:0] sum_q [2];
  logic [WsumW-1:0]   wsum_q [2];
  logic [31:0]        p_q;
  logic               p_one_q;
  logic [16:0]        w_q;
  logic [SumW-1:0]    mag_q, scaled_q;
  logic               neg_q;
  logic [31:0]        tmp_q, hi_q, wss_q;
  logic [32:0]        wsw_q;
  out_beat_t          res_q;

  logic [TimeW-1:0]   dt;
  logic signed [SumW-1:0] cur_sum, sat_s, half_s;
  logic [WsumW-1:0]   cur_wsum;
  logic signed [15:0] smp;
  logic signed [49:0] smp_ext, sc_ext, add_s;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               div_start, div_busy, div_done, div_ovf;
  logic [DivNumW-1:0] div_num;
  logic [31:0]        div_den;
  logic [DivQW-1:0]   quo;
  logic signed [15:0] avg_val;
  logic               cmp_hit;

  // flags and shared operands
  always_comb begin
    dt       = in_q.sample_time_us - last_smp_q;
    cur_sum  = sum_q[cmd_i.ch];
    cur_wsum = wsum_q[cmd_i.ch];
    smp      = cmd_i.ch ? in_q.quality : in_q.signal;
    cmp_hit  = valid_q[cmp_idx_i] && (rd_q.addr == in_q.neighbor_addr);
  end

  assign sts_o.action   = in_q.action;
  assign sts_o.bad      = (in_q.signal == 16'sd0) && (in_q.quality == 16'sd0);
  assign sts_o.hit      = hit_q;
  assign sts_o.free     = free_q;
  assign sts_o.rpt      = in_q.sample_time_us == last_smp_q;
  assign sts_o.older    = in_q.sample_time_us < last_smp_q;
  assign sts_o.w_zero   = (den_q == '0) || (dt >= {13'b0, den_q, 5'b0});
  assign sts_o.div_done = div_done;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_EXP: begin
        mul_a = p_q;
        mul_b = decay_c(cmd_i.k);
      end
      OP_MLO: begin
        mul_a = mag_q[31:0];
        mul_b = {16'b0, w_q[15:0]};
      end
      OP_MHI: begin
        mul_a = {16'b0, mag_q[47:32]};
        mul_b = {16'b0, w_q[15:0]};
      end
      OP_MWS: begin
        mul_a = cur_wsum;
        mul_b = {16'b0, w_q[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = {32'b0, mul_a} * {32'b0, mul_b};
  end

  // add the sample, saturate, and halve toward zero
  always_comb begin
    smp_ext = {{18{smp[15]}}, smp, 16'b0};
    sc_ext  = {2'b0, scaled_q};
    if (neg_q) begin
      sc_ext = -sc_ext;
    end
    add_s = sc_ext + smp_ext;
    if (add_s[49:47] == 3'b000 || add_s[49:47] == 3'b111) begin
      sat_s = add_s[47:0];
    end else if (add_s[49]) begin
      sat_s = {1'b1, 47'b0};
    end else begin
      sat_s = {1'b0, {47{1'b1}}};
    end
    half_s = cur_sum[47] ? ((cur_sum + 48'sd1) >>> 1) : (cur_sum >>> 1);
  end

  // saturate the quotient to 16 bits
  always_comb begin
    if (cur_wsum == '0) begin
      avg_val = 16'sd0;
    end else if (neg_q) begin
      avg_val = (div_ovf || quo > 21'd32768) ? 16'sh8000 : $signed(~quo[15:0] + 16'd1);
    end else begin
      avg_val = (div_ovf || quo > 21'd32767) ? 16'sh7FFF : $signed(quo[15:0]);
    end
  end

  // divider operands
  always_comb begin
    div_start = (cmd_i.op == OP_DIV_R) || (cmd_i.op == OP_QDIV);
    if (cmd_i.op == OP_DIV_R) begin
      div_num = {1'b0, dt[34:0], 16'b0};
      div_den = {2'b0, den_q};
    end else begin
      div_num = {4'b0, mag_q};
      div_den = cur_wsum;
    end
  end

  nlqt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo),
    .ovf_o   (div_ovf)
  );

  // table write port
  always_comb begin
    wr_en  = (cmd_i.op == OP_NEW) || (cmd_i.op == OP_WRITE);
    wr_idx = (cmd_i.op == OP_NEW) ? free_idx_q : hit_idx_q;
    if (cmd_i.op == OP_NEW) begin
      wr_data = '{addr: in_q.neighbor_addr, last_sample: in_q.sample_time_us,
                  upd_time: in_q.now_us,
                  sig_sum: {{16{in_q.signal[15]}}, in_q.signal, 16'b0},
                  sig_wsum: WsumOne,
                  qual_sum: {{16{in_q.quality[15]}}, in_q.quality, 16'b0},
                  qual_wsum: WsumOne};
    end else begin
      wr_data = '{addr: in_q.neighbor_addr, last_sample: in_q.sample_time_us,
                  upd_time: in_q.now_us, sig_sum: sum_q[0], sig_wsum: wsum_q[0],
                  qual_sum: sum_q[1], qual_wsum: wsum_q[1]};
    end
  end

  // table memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  // valid bits, time constant, scan flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      den_q   <= DenReset;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        valid_q <= '0;
        den_q   <= DenW'({10'b0, cfg_data_i} * {20'b0, UsPerMs});
      end else if (cmd_i.op == OP_NEW) begin
        valid_q[free_idx_q] <= 1'b1;
      end else if (cmd_i.op == OP_CLR_VALID) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
      if (cmd_i.op == OP_START) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.cmp_en) begin
        if (cmp_hit) begin
          hit_q <= 1'b1;
        end
        if (!valid_q[cmp_idx_i]) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_START) begin
      in_q <= in_i;
      res_q <= '0;
    end
    if (cmd_i.cmp_en) begin
      if (cmp_hit) begin
        hit_idx_q  <= cmp_idx_i;
        last_smp_q <= rd_q.last_sample;
        last_upd_q <= rd_q.upd_time;
        sum_q[0]   <= rd_q.sig_sum;
        wsum_q[0]  <= rd_q.sig_wsum;
        sum_q[1]   <= rd_q.qual_sum;
        wsum_q[1]  <= rd_q.qual_wsum;
      end
      if (!valid_q[cmp_idx_i] && !free_q) begin
        free_idx_q <= cmp_idx_i;
      end
    end
    if (cmd_i.status_we) begin
      res_q.status <= cmd_i.status;
    end
    case (cmd_i.op)
      OP_W_ONE:  w_q <= WOne;
      OP_W_ZERO: w_q <= '0;
      OP_DIV_R:  p_one_q <= 1'b1;
      OP_EXP: begin
        if (quo[cmd_i.k]) begin
          p_one_q <= 1'b0;
          p_q     <= p_one_q ? decay_c(cmd_i.k) : prod[63:32];
        end
      end
      OP_W_P: w_q <= p_one_q ? WOne : 17'(({1'b0, p_q} + 33'h8000) >> 16);
      OP_MAG: begin
        neg_q <= cur_sum[47];
        mag_q <= cur_sum[47] ? 48'(-cur_sum) : cur_sum;
      end
      OP_MLO: tmp_q <= prod[47:16];
      OP_MHI: hi_q  <= prod[31:0];
      OP_MWS: wss_q <= w_q[16] ? cur_wsum : prod[47:16];
      OP_COMB: scaled_q <= w_q[16] ? mag_q : ({hi_q, 16'b0} + {16'b0, tmp_q});
      OP_ADD: begin
        sum_q[cmd_i.ch] <= sat_s;
        wsw_q           <= {1'b0, wss_q} + {1'b0, WsumOne};
      end
      OP_NORM: begin
        if (wsw_q > 33'h0_8000_0000) begin
          wsum_q[cmd_i.ch] <= wsw_q[32:1];
          sum_q[cmd_i.ch]  <= half_s;
        end else begin
          wsum_q[cmd_i.ch] <= wsw_q[31:0];
        end
      end
      OP_QRES: begin
        if (cmd_i.ch) begin
          res_q.avg_quality    <= avg_val;
          res_q.last_update_us <= last_upd_q;
        end else begin
          res_q.avg_signal <= avg_val;
        end
      end
      default: ;
    endcase
  end

  assign out_o = res_q;

  // a new entry only goes into a free slot of an unknown neighbor
  a_new_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_NEW) |-> (free_q && !hit_q))
    else $error("new entry without a free slot");

  // writeback, removal and query only touch a matched entry
  a_hit_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WRITE || cmd_i.op == OP_CLR_VALID || cmd_i.op == OP_QRES) |-> hit_q)
    else $error("entry access without a match");

  // divider result is read only once it has settled
  a_div_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EXP || cmd_i.op == OP_QRES) |-> !div_busy)
    else $error("divider result read while busy");

endmodule

// File: src/nlqt_ctrl.sv
// Controller state machine: table scan, decision, and the update and query sequences.
// Depends on nlqt_pkg.
module nlqt_ctrl
  import nlqt_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sts_t          sts_i,
  output cmd_t          cmd_o,
  output logic [IW-1:0] rd_idx_o,
  output logic [IW-1:0] cmp_idx_o
);

  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] CntEnd = CW'(ENTRIES);
  localparam logic [2:0] SubLast = 3'd6;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SCAN   = 13'b0000000000010,
    S_DECIDE = 13'b0000000000100,
    S_RWAIT  = 13'b0000000001000,
    S_EXP    = 13'b0000000010000,
    S_WSET   = 13'b0000000100000,
    S_ACC    = 13'b0000001000000,
    S_WRITE  = 13'b0000010000000,
    S_QMAG   = 13'b0000100000000,
    S_QDIV   = 13'b0001000000000,
    S_QWAIT  = 13'b0010000000000,
    S_QRES   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [ExpW-1:0] k_q, k_d;
  logic [2:0]      sub_q, sub_d;
  logic            ch_q, ch_d;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmp_idx_d = cmp_idx_q;
    k_d       = k_q;
    sub_d     = sub_q;
    ch_d      = ch_q;
    cmd_o     = '{op: OP_NONE, ch: ch_q, k: k_q, rd_en: 1'b0, cmp_en: 1'b0,
                  status_we: 1'b0, status: ST_INSERTED};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          cnt_d    = '0;
          state_d  = S_SCAN;
        end
      end
      // read one entry a cycle, compare the one read before
      S_SCAN: begin
        cmd_o.rd_en  = cnt_q != CntEnd;
        cmd_o.cmp_en = cnt_q != '0;
        cmp_idx_d    = cnt_q[IW-1:0];
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntEnd) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.status_we = 1'b1;
        state_d         = S_OUT;
        case (sts_i.action)
          ACT_REMOVE: begin
            if (sts_i.hit) begin
              cmd_o.op     = OP_CLR_VALID;
              cmd_o.status = ST_REMOVED;
            end else begin
              cmd_o.status = ST_REMOVE_MISSING;
            end
          end
          ACT_ADD: begin
            if (sts_i.bad) begin
              cmd_o.status = ST_BAD_IGNORED;
            end else if (!sts_i.hit) begin
              if (sts_i.free) begin
                cmd_o.op     = OP_NEW;
                cmd_o.status = ST_INSERTED;
              end else begin
                cmd_o.status = ST_TABLE_FULL;
              end
            end else if (sts_i.rpt) begin
              cmd_o.status = ST_REPEAT_IGNORED;
            end else begin
              cmd_o.status_we = 1'b0;
              ch_d  = 1'b0;
              sub_d = '0;
              if (sts_i.older) begin
                cmd_o.op = OP_W_ONE;
                state_d  = S_ACC;
              end else if (sts_i.w_zero) begin
                cmd_o.op = OP_W_ZERO;
                state_d  = S_ACC;
              end else begin
                cmd_o.op = OP_DIV_R;
                state_d  = S_RWAIT;
              end
            end
          end
          default: begin
            if (sts_i.hit) begin
              cmd_o.status_we = 1'b0;
              ch_d    = 1'b0;
              state_d = S_QMAG;
            end else begin
              cmd_o.status = ST_NOT_FOUND;
            end
          end
        endcase
      end
      S_RWAIT: begin
        if (sts_i.div_done) begin
          k_d     = '0;
          state_d = S_EXP;
        end
      end
      // one decay factor per bit of the ratio
      S_EXP: begin
        cmd_o.op = OP_EXP;
        k_d      = k_q + 1'b1;
        if (k_q == ExpLast) begin
          state_d = S_WSET;
        end
      end
      S_WSET: begin
        cmd_o.op = OP_W_P;
        ch_d     = 1'b0;
        sub_d    = '0;
        state_d  = S_ACC;
      end
      // decay and accumulate signal, then quality
      S_ACC: begin
        case (sub_q)
          3'd0:    cmd_o.op = OP_MAG;
          3'd1:    cmd_o.op = OP_MLO;
          3'd2:    cmd_o.op = OP_MHI;
          3'd3:    cmd_o.op = OP_MWS;
          3'd4:    cmd_o.op = OP_COMB;
          3'd5:    cmd_o.op = OP_ADD;
          3'd6:    cmd_o.op = OP_NORM;
          default: cmd_o.op = OP_NONE;
        endcase
        sub_d = sub_q + 1'b1;
        if (sub_q == SubLast) begin
          sub_d = '0;
          if (ch_q) begin
            state_d = S_WRITE;
          end else begin
            ch_d = 1'b1;
          end
        end
      end
      S_WRITE: begin
        cmd_o.op        = OP_WRITE;
        cmd_o.status_we = 1'b1;
        cmd_o.status    = ST_UPDATED;
        state_d         = S_OUT;
      end
      S_QMAG: begin
        cmd_o.op = OP_MAG;
        state_d  = S_QDIV;
      end
      S_QDIV: begin
        cmd_o.op = OP_QDIV;
        state_d  = S_QWAIT;
      end
      S_QWAIT: begin
        if (sts_i.div_done) begin
          state_d = S_QRES;
        end
      end
      S_QRES: begin
        cmd_o.op = OP_QRES;
        if (ch_q) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = ST_FOUND;
          state_d         = S_OUT;
        end else begin
          ch_d    = 1'b1;
          state_d = S_QMAG;
        end
      end
      // hold the result beat until taken
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cmp_idx_q <= '0;
      k_q       <= '0;
      sub_q     <= '0;
      ch_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_idx_q <= cmp_idx_d;
      k_q       <= k_d;
      sub_q     <= sub_d;
      ch_q      <= ch_d;
    end
  end

  assign rd_idx_o  = cnt_q[IW-1:0];
  assign cmp_idx_o = cmp_idx_q;

endmodule

// File: src/neighbor_link_quality_tracker.sv
// Top level of the neighbor link quality tracker: controller plus datapath.
// Depends on nlqt_pkg, nlqt_ctrl and nlqt_dp.
//
// One item is handled at a time. Every item first scans the table through its
// single read port, one entry per cycle. A remove, a dropped sample, a new
// entry or a miss then goes from the decision to its result beat. An update
// of a known neighbor adds a ratio division, the exponential (one decay factor
// per ratio bit through one 32x32 multiplier) and the accumulate steps for
// signal and quality. An update with an older sample time or a zero weight
// skips the division and the exponential. A query runs two divisions, one per
// average. A write of tau_ms takes effect at once and empties the table.
module neighbor_link_quality_tracker
  import nlqt_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_beat_t        in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_beat_t       out_o,
  input  logic            cfg_we_i,
  input  logic [TauW-1:0] cfg_data_i
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] rd_idx, cmp_idx;

  nlqt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx),
    .cmp_idx_o   (cmp_idx)
  );

  nlqt_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .rd_idx_i   (rd_idx),
    .cmp_idx_i  (cmp_idx),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule
